// ----- sv/sgm_pkg.sv -----
package sgm_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned IMG_W_W    = 11;
  localparam int unsigned IMG_H_W    = 12;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned GRAD_W     = 10;
  localparam int unsigned SQ_W       = 2 * GRAD_W + 1;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned ROOT_W     = 8;
  localparam int unsigned BIT_IDX_W  = 3;

  localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd512;
  localparam logic [IMG_H_W-1:0] IMG_H_RESET = 12'd512;
  localparam logic [IMG_H_W-1:0] IMG_H_MIN   = 12'd3;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_e;

  // One window's gradient, handed from the front part to the back part.
  typedef struct packed {
    logic [GRAD_W-1:0] gx_abs;
    logic [GRAD_W-1:0] gy_abs;
    logic              last;
  } grad_t;

endpackage

// ----- sv/sobel_gradient_magnitude_3x3.sv -----
// Channel   Direction  Handshake               Payload
// config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
// pixels    in         push_i / full_o         pixel_i
// results   out        empty_o / pop_i         magnitude_o, frame_last_o
//
// The front part cannot take items in back-to-back cycles: the line store read at
// the new column is registered, so full_o is high in the cycle after each item.
// The back part works through load, square, eight root bits and hand-off per result,
// cutting the root short when the sum saturates, so long interior runs stall the input via the queue.
// Reset clears the counters, the window and the handshake state and loads both sizes
// with 512; the line stores are not cleared. A stalled result side fills the queue.

module sobel_gradient_magnitude_3x3 #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes, taken whenever cfg_we_i is high.
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Pixel input queue side.
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [sgm_pkg::PIX_W-1:0]      pixel_i,
  // Result output queue side.
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [sgm_pkg::ROOT_W-1:0]     magnitude_o,
  output logic                           frame_last_o
);

  logic           q_push, q_full, q_pop, q_empty;
  sgm_pkg::grad_t q_wdata, q_rdata;

  // Front: frame counters, both line stores, the window and the Sobel sums.
  // Only items that complete an interior window reach the queue.
  sgm_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push_i),
    .pixel_i    (pixel_i),
    .full_o     (full_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  // The queue decouples the pixel stream from the slow square root.
  sgm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  // Back: squares, saturating integer square root and the output register.
  sgm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .magnitude_o (magnitude_o),
    .frame_last_o(frame_last_o)
  );

endmodule

// ----- sv/sgm_ram.sv -----
module sgm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sgm_front.sv -----
module sgm_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             push_i,
  input  logic [sgm_pkg::PIX_W-1:0]        pixel_i,
  output logic                             full_o,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output sgm_pkg::grad_t                   q_data_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CLW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EXT_W = (CLW > sgm_pkg::IMG_W_W) ? CLW : sgm_pkg::IMG_W_W;
  localparam int unsigned PW    = sgm_pkg::PIX_W;
  localparam int unsigned SW    = sgm_pkg::SUM_W;

  logic [sgm_pkg::IMG_W_W-1:0] width_q;
  logic [sgm_pkg::IMG_H_W-1:0] height_q;
  logic [COL_W-1:0]            col_q, col_d;
  logic [sgm_pkg::IMG_H_W-1:0] row_q, row_d;
  logic                        rd_ok_q;
  logic [PW-1:0]               win_q [6];

  logic [PW-1:0]               top, mid;
  logic                        accept;
  logic [EXT_W-1:0]            width_ext, w_eff, col_ext;
  logic [sgm_pkg::IMG_H_W-1:0] h_eff;
  logic                        col_last, row_last, in_frame;

  logic signed [SW-1:0] s_top, s_mid, s_bot, s_w0, s_w1, s_w2, s_w3, s_w5;
  logic signed [SW-1:0] gx, gy, gx_abs, gy_abs;

  assign accept = push_i && !full_o;
  assign full_o = !rd_ok_q || q_full_i;

  // Effective frame size after clamping the registers to their legal ranges.
  always_comb begin
    width_ext = EXT_W'(width_q);
    if (width_ext < EXT_W'(3)) begin
      w_eff = EXT_W'(3);
    end else if (width_ext > EXT_W'(MAX_WIDTH)) begin
      w_eff = EXT_W'(MAX_WIDTH);
    end else begin
      w_eff = width_ext;
    end
    h_eff = (height_q < sgm_pkg::IMG_H_MIN) ? sgm_pkg::IMG_H_MIN : height_q;
  end

  assign col_ext  = EXT_W'(col_q);
  assign col_last = col_ext >= (w_eff - EXT_W'(1));
  assign row_last = row_q >= (h_eff - sgm_pkg::IMG_H_W'(1));
  assign in_frame = (row_q >= sgm_pkg::IMG_H_W'(2)) && (col_q >= COL_W'(2)) &&
                    (col_ext < w_eff) && (row_q < h_eff);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + sgm_pkg::IMG_H_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sgm_pkg::IMG_W_RESET;
      height_q <= sgm_pkg::IMG_H_RESET;
      col_q    <= '0;
      row_q    <= '0;
      rd_ok_q  <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (sgm_pkg::reg_idx_e'(cfg_idx_i))
          sgm_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[sgm_pkg::IMG_W_W-1:0];
          sgm_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[sgm_pkg::IMG_H_W-1:0];
          default: ;
        endcase
      end
      col_q   <= col_d;
      row_q   <= row_d;
      // The line store read at the new column is ready in the next cycle.
      rd_ok_q <= !accept;
      if (accept) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top;
        win_q[4] <= mid;
        win_q[5] <= pixel_i;
      end
    end
  end

  sgm_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_WIDTH)
  ) u_line_upper (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(col_q),
    .wdata_i(mid),
    .raddr_i(col_q),
    .rdata_o(top)
  );

  sgm_ram #(
    .WIDTH(PW),
    .DEPTH(MAX_WIDTH)
  ) u_line_lower (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(col_q),
    .wdata_i(pixel_i),
    .raddr_i(col_q),
    .rdata_o(mid)
  );

  // Sobel sums over the window; both stay within plus or minus 1020.
  always_comb begin
    s_top = signed'(SW'(top));
    s_mid = signed'(SW'(mid));
    s_bot = signed'(SW'(pixel_i));
    s_w0  = signed'(SW'(win_q[0]));
    s_w1  = signed'(SW'(win_q[1]));
    s_w2  = signed'(SW'(win_q[2]));
    s_w3  = signed'(SW'(win_q[3]));
    s_w5  = signed'(SW'(win_q[5]));
    gx = (s_top - s_w0) + ((s_mid - s_w1) <<< 1) + (s_bot - s_w2);
    gy = (s_w2 - s_w0) + ((s_w5 - s_w3) <<< 1) + (s_bot - s_top);
    gx_abs = (gx < 0) ? -gx : gx;
    gy_abs = (gy < 0) ? -gy : gy;
  end

  assign q_push_o        = accept && in_frame;
  assign q_data_o.gx_abs = gx_abs[sgm_pkg::GRAD_W-1:0];
  assign q_data_o.gy_abs = gy_abs[sgm_pkg::GRAD_W-1:0];
  assign q_data_o.last   = row_last && col_last && (row_q == h_eff - sgm_pkg::IMG_H_W'(1)) &&
                           (col_ext == w_eff - EXT_W'(1));

endmodule

// ----- sv/sgm_queue.sv -----
module sgm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sgm_pkg::grad_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output sgm_pkg::grad_t data_o,
  output logic           empty_o
);

  localparam int unsigned DEPTH = sgm_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sgm_pkg::grad_t   entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/sgm_back.sv -----
module sgm_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  sgm_pkg::grad_t               q_data_i,
  output logic                         q_pop_o,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [sgm_pkg::ROOT_W-1:0]   magnitude_o,
  output logic                         frame_last_o
);

  localparam int unsigned RW = sgm_pkg::ROOT_W;
  localparam int unsigned QW = 2 * sgm_pkg::ROOT_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SQUARE = 4'b0010,
    ST_ROOT   = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [sgm_pkg::GRAD_W-1:0]    gx_q, gy_q;
  logic                          last_q;
  logic [sgm_pkg::SQ_W-1:0]      sq_q;
  logic [RW-1:0]                 root_q;
  logic [sgm_pkg::BIT_IDX_W-1:0] bit_q;
  logic                          out_valid_q;
  logic [RW-1:0]                 out_mag_q;
  logic                          out_last_q;

  logic [RW-1:0]                 trial;
  logic [QW-1:0]                 trial_sq;
  logic                          saturate, out_free;

  assign q_pop_o  = (state_q == ST_IDLE) && !q_empty_i;
  assign out_free = !out_valid_q || pop_i;
  assign saturate = sq_q[sgm_pkg::SQ_W-1:QW] != '0;
  assign trial    = root_q | (RW'(1) << bit_q);
  assign trial_sq = trial * trial;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (!q_empty_i) state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ROOT;
      ST_ROOT:   if (saturate || bit_q == '0) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        gx_q   <= q_data_i.gx_abs;
        gy_q   <= q_data_i.gy_abs;
        last_q <= q_data_i.last;
      end
      ST_SQUARE: begin
        sq_q   <= sgm_pkg::SQ_W'(gx_q * gx_q) + sgm_pkg::SQ_W'(gy_q * gy_q);
        root_q <= '0;
        bit_q  <= sgm_pkg::BIT_IDX_W'(RW - 1);
      end
      ST_ROOT: begin
        if (saturate) begin
          root_q <= '1;
        end else if (trial_sq <= sq_q[QW-1:0]) begin
          root_q <= trial;
        end
        bit_q <= bit_q - sgm_pkg::BIT_IDX_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_mag_q  <= root_q;
          out_last_q <= last_q;
        end
      end
      default: ;
    endcase
  end

  assign empty_o      = !out_valid_q;
  assign magnitude_o  = out_mag_q;
  assign frame_last_o = out_last_q;

endmodule

// ----- sv/sgm_checker.sv -----
module sgm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push_i,
  input logic                           full_o,
  input logic                           empty_o,
  input logic                           pop_i,
  input logic [sgm_pkg::ROOT_W-1:0]     magnitude_o,
  input logic                           frame_last_o
);

  // Nothing can be waiting on the result side right after reset.
  a_empty_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> empty_o)
    else $error("result shown right after reset");

  // The line store read is registered, so an accepted pixel is never
  // followed by another in the next cycle.
  a_gap_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !full_o |=> full_o)
    else $error("pixel accepted in back-to-back cycles");

  // A waiting result holds its value until it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(magnitude_o) && $stable(frame_last_o))
    else $error("waiting result changed or vanished");

  // The handshake outputs and a shown result never carry unknown bits.
  a_known_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(full_o) && !$isunknown(empty_o) &&
    (empty_o || !$isunknown({magnitude_o, frame_last_o})))
    else $error("unknown value on an output");

endmodule

bind sobel_gradient_magnitude_3x3 sgm_checker u_sgm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push_i      (push_i),
  .full_o      (full_o),
  .empty_o     (empty_o),
  .pop_i       (pop_i),
  .magnitude_o (magnitude_o),
  .frame_last_o(frame_last_o)
);
